[design/isl_pkg.sv]
// Shared types, codes and character helpers of the indentation-aware lexer.
// No dependencies; isl_ctrl, isl_dp, the top level and the testbench refer to this package.
package isl_pkg;

	// Scanner modes.
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_INDENT = 3'd1;
	localparam logic [2:0] MODE_IDENT  = 3'd2;
	localparam logic [2:0] MODE_NUM    = 3'd3;
	localparam logic [2:0] MODE_STR    = 3'd4;
	localparam logic [2:0] MODE_OP     = 3'd5;

	// Controller phases, one per kind of work step.
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_ESC   = 4'd1;
	localparam logic [3:0] PH_BODY  = 4'd2;
	localparam logic [3:0] PH_IND   = 4'd3;
	localparam logic [3:0] PH_SCAN  = 4'd4;
	localparam logic [3:0] PH_CLOSE = 4'd5;
	localparam logic [3:0] PH_DED   = 4'd6;
	localparam logic [3:0] PH_END   = 4'd7;
	localparam logic [3:0] PH_FIN   = 4'd8;

	// Token type codes.
	localparam logic [5:0] TY_END        = 6'd0;
	localparam logic [5:0] TY_INT        = 6'd1;
	localparam logic [5:0] TY_FLOAT      = 6'd2;
	localparam logic [5:0] TY_STRING     = 6'd3;
	localparam logic [5:0] TY_IDENTIFIER = 6'd4;
	localparam logic [5:0] TY_PLUS       = 6'd5;
	localparam logic [5:0] TY_MINUS      = 6'd6;
	localparam logic [5:0] TY_STAR       = 6'd7;
	localparam logic [5:0] TY_SLASH      = 6'd8;
	localparam logic [5:0] TY_POW        = 6'd9;
	localparam logic [5:0] TY_SHL        = 6'd10;
	localparam logic [5:0] TY_SHR        = 6'd11;
	localparam logic [5:0] TY_AMP        = 6'd12;
	localparam logic [5:0] TY_BAR        = 6'd13;
	localparam logic [5:0] TY_CARET      = 6'd14;
	localparam logic [5:0] TY_TILDE      = 6'd15;
	localparam logic [5:0] TY_EQ         = 6'd16;
	localparam logic [5:0] TY_NE         = 6'd17;
	localparam logic [5:0] TY_LT         = 6'd18;
	localparam logic [5:0] TY_GT         = 6'd19;
	localparam logic [5:0] TY_LE         = 6'd20;
	localparam logic [5:0] TY_GE         = 6'd21;
	localparam logic [5:0] TY_ASSIGN     = 6'd22;
	localparam logic [5:0] TY_PLUS_EQ    = 6'd23;
	localparam logic [5:0] TY_MINUS_EQ   = 6'd24;
	localparam logic [5:0] TY_STAR_EQ    = 6'd25;
	localparam logic [5:0] TY_SLASH_EQ   = 6'd26;
	localparam logic [5:0] TY_SHL_EQ     = 6'd27;
	localparam logic [5:0] TY_SHR_EQ     = 6'd28;
	localparam logic [5:0] TY_AMP_EQ     = 6'd29;
	localparam logic [5:0] TY_BAR_EQ     = 6'd30;
	localparam logic [5:0] TY_CARET_EQ   = 6'd31;
	localparam logic [5:0] TY_LPAREN     = 6'd32;
	localparam logic [5:0] TY_RPAREN     = 6'd33;
	localparam logic [5:0] TY_LBRACK     = 6'd34;
	localparam logic [5:0] TY_RBRACK     = 6'd35;
	localparam logic [5:0] TY_COMMA      = 6'd36;
	localparam logic [5:0] TY_COLON      = 6'd37;
	localparam logic [5:0] TY_NEWLINE    = 6'd49;
	localparam logic [5:0] TY_INDENT     = 6'd50;
	localparam logic [5:0] TY_DEDENT     = 6'd51;
	localparam logic [5:0] TY_UNKNOWN    = 6'd52;
	localparam logic [5:0] TY_TOO_DEEP   = 6'd53;

	// Register map.
	localparam logic [1:0] REG_TAB_WIDTH = 2'd0;
	localparam logic [3:0] TAB_RESET     = 4'd4;

	// Saturation limits.
	localparam logic [19:0] LINE_SAT   = 20'hFFFFF;
	localparam logic [15:0] COL_SAT    = 16'hFFFF;
	localparam logic [30:0] VALUE_SAT  = 31'h7FFFFFFF;
	localparam logic [11:0] INDENT_SAT = 12'hFFF;
	// Largest accumulator that can take one more digit: digits 0..7 and 8..9.
	localparam logic [30:0] ACC_LIM_LO = 31'((2147483647 - 7) / 10);
	localparam logic [30:0] ACC_LIM_HI = 31'((2147483647 - 9) / 10);

	// Keyword table, index order of the candidate mask.
	localparam int KW_NUM = 8;
	localparam logic [7:0] KW_CH [KW_NUM][7] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "i", "f", 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00},
		'{"p", "r", "i", "n", "t", 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd3, 3'd6, 3'd5};
	localparam logic [5:0] KW_CODE [KW_NUM] = '{6'd38, 6'd44, 6'd39, 6'd40, 6'd41, 6'd42,
		6'd43, 6'd48};

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  text_byte;
		logic [5:0]  token_type;
		logic [19:0] token_line;
		logic [15:0] token_column;
		logic [8:0]  token_length;
		logic [30:0] int_value;
		logic        last_of_run;
	} isl_rec_t;

	typedef struct packed {
		logic       accept;
		logic [3:0] phase;
		logic       step;
		logic       finish;
	} isl_cmd_t;

	typedef struct packed {
		logic esc_go;
		logic body_ind;
		logic body_scan;
		logic body_close;
		logic scan_close;
		logic ind_stay;
		logic ded_more;
		logic eoi;
		logic can_gen;
		logic flush_ok;
	} isl_stat_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_look_op(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "<" || c == ">" ||
			c == "=" || c == "!" || c == "&" || c == "|" || c == "^";
	endfunction

	function automatic logic [5:0] single_code(input logic [7:0] op);
		logic [5:0] t;
		unique case (op)
			"+": t = TY_PLUS;
			"-": t = TY_MINUS;
			"*": t = TY_STAR;
			"/": t = TY_SLASH;
			"<": t = TY_LT;
			">": t = TY_GT;
			"=": t = TY_ASSIGN;
			"&": t = TY_AMP;
			"|": t = TY_BAR;
			"^": t = TY_CARET;
			default: t = TY_UNKNOWN;
		endcase
		return t;
	endfunction

	function automatic logic [5:0] eq_code(input logic [7:0] op);
		logic [5:0] t;
		unique case (op)
			"+": t = TY_PLUS_EQ;
			"-": t = TY_MINUS_EQ;
			"*": t = TY_STAR_EQ;
			"/": t = TY_SLASH_EQ;
			"<": t = TY_LE;
			">": t = TY_GE;
			"=": t = TY_EQ;
			"!": t = TY_NE;
			"&": t = TY_AMP_EQ;
			"|": t = TY_BAR_EQ;
			default: t = TY_CARET_EQ;
		endcase
		return t;
	endfunction

	function automatic logic [5:0] punct_code(input logic [7:0] c);
		logic [5:0] t;
		unique case (c)
			"~": t = TY_TILDE;
			"(": t = TY_LPAREN;
			")": t = TY_RPAREN;
			"[": t = TY_LBRACK;
			"]": t = TY_RBRACK;
			",": t = TY_COMMA;
			":": t = TY_COLON;
			default: t = TY_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage

[design/isl_if.sv]
// Stream interfaces of the lexer: source bytes in, records out.
// Depends on nothing; payload widths are fixed by the record format.
interface isl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;
	modport source (output valid, char_byte, end_of_input, input ready);
	modport sink (input valid, char_byte, end_of_input, output ready);
endinterface

interface isl_rec_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [7:0]  text_byte;
	logic [5:0]  token_type;
	logic [19:0] token_line;
	logic [15:0] token_column;
	logic [8:0]  token_length;
	logic [30:0] int_value;
	logic        last_of_run;
	modport source (output valid, record_kind, text_byte, token_type, token_line,
		token_column, token_length, int_value, last_of_run, input ready);
	modport sink (input valid, record_kind, text_byte, token_type, token_line,
		token_column, token_length, int_value, last_of_run, output ready);
endinterface

[design/isl_ctrl.sv]
// Phase sequencer of the lexer: walks one accepted byte through its work steps.
// Depends on isl_pkg for phase codes and the command and status structs.
module isl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  isl_pkg::isl_stat_t    stat,
	output isl_pkg::isl_cmd_t     cmd
);

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       work;

	always_comb begin
		in_ready   = (state_q == isl_pkg::PH_IDLE);
		work       = (state_q != isl_pkg::PH_IDLE) && (state_q != isl_pkg::PH_FIN);
		cmd.accept = in_ready && in_valid;
		cmd.phase  = state_q;
		cmd.step   = work && stat.can_gen;
		cmd.finish = (state_q == isl_pkg::PH_FIN) && stat.flush_ok;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isl_pkg::PH_IDLE: begin
				if (cmd.accept) state_d = isl_pkg::PH_ESC;
			end
			isl_pkg::PH_ESC: begin
				if (cmd.step) state_d = isl_pkg::PH_BODY;
			end
			isl_pkg::PH_BODY: begin
				if (cmd.step) begin
					priority if (stat.eoi) state_d = isl_pkg::PH_DED;
					else if (stat.body_ind) state_d = isl_pkg::PH_IND;
					else if (stat.body_scan) state_d = isl_pkg::PH_SCAN;
					else if (stat.body_close) state_d = isl_pkg::PH_CLOSE;
					else state_d = isl_pkg::PH_FIN;
				end
			end
			isl_pkg::PH_IND: begin
				if (cmd.step && !stat.ind_stay) state_d = isl_pkg::PH_SCAN;
			end
			isl_pkg::PH_SCAN: begin
				if (cmd.step) state_d = stat.scan_close ? isl_pkg::PH_CLOSE : isl_pkg::PH_FIN;
			end
			isl_pkg::PH_CLOSE: begin
				if (cmd.step) state_d = isl_pkg::PH_FIN;
			end
			isl_pkg::PH_DED: begin
				if (cmd.step && !stat.ded_more) state_d = isl_pkg::PH_END;
			end
			isl_pkg::PH_END: begin
				if (cmd.step) state_d = isl_pkg::PH_FIN;
			end
			isl_pkg::PH_FIN: begin
				if (cmd.finish) state_d = isl_pkg::PH_IDLE;
			end
			default: state_d = isl_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isl_pkg::PH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/isl_dp.sv]
// Lexer datapath: scanner state, indentation stack, record hold and output registers.
// Depends on isl_pkg; driven step by step by the commands of isl_ctrl.
module isl_dp #(
	parameter int TOKEN_MAX_BYTES = 256,
	parameter int INDENT_DEPTH    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isl_pkg::isl_cmd_t     cmd,
	output isl_pkg::isl_stat_t    stat,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_input,
	input  logic [3:0]            tab_width,
	output isl_pkg::isl_rec_t     rec,
	output logic                  rec_valid,
	input  logic                  rec_ready
);

	localparam int CW = $clog2(TOKEN_MAX_BYTES + 1);
	localparam int TW = $clog2(INDENT_DEPTH);
	localparam logic [CW-1:0] CNT_MAX = CW'(TOKEN_MAX_BYTES);
	localparam logic [TW-1:0] TOP_LAST = TW'(INDENT_DEPTH - 1);

	// Scanner state.
	logic [2:0]    mode_q, mode_d;
	logic [7:0]    pend_q, pend_d;
	logic [1:0]    la_q, la_d;
	logic [7:0]    quote_q, quote_d;
	logic          esc_q, esc_d;
	logic          float_q, float_d;
	logic [7:0]    kw_q, kw_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [30:0]   acc_q, acc_d;
	logic [11:0]   icnt_q, icnt_d;
	logic [TW-1:0] top_q, top_d;
	logic [19:0]   line_q, line_d;
	logic [15:0]   col_q, col_d;
	logic [19:0]   sline_q, sline_d;
	logic [15:0]   scol_q, scol_d;
	logic [11:0]   lv_q [INDENT_DEPTH];

	// Per-byte work registers.
	logic [7:0]    byte_q;
	logic          eoi_q;
	logic          escdef_q, escdef_d;
	logic [5:0]    ctype_q, ctype_d;
	logic          nl_q, nl_d;

	// Record hold and output.
	isl_pkg::isl_rec_t hold_q, out_q, gen;
	logic              hold_v_q, out_v_q;
	logic              gen_v, out_free;

	logic [5:0]  cur_type;
	logic [11:0] cur_lvl;
	logic [11:0] nxt_lvl;
	logic        full, push;
	logic        txt_v, dsc_v, mrk_v;
	logic [7:0]  txt_b;
	logic [5:0]  dsc_t, mrk_t;
	logic [15:0] mrk_col;
	logic [7:0]  c;
	logic [3:0]  dv;
	logic [30:0] lim;
	logic [12:0] tsum;

	assign c        = byte_q;
	assign full     = (cnt_q >= CNT_MAX);
	assign cur_lvl  = (top_q == '0) ? 12'd0 : lv_q[top_q];
	// Level that becomes the top once the current one is popped.
	assign nxt_lvl  = (top_q <= TW'(1)) ? 12'd0 : lv_q[top_q - TW'(1)];
	assign out_free = !out_v_q || rec_ready;
	assign dv       = 4'(c - 8'h30);
	assign lim      = (dv <= 4'd7) ? isl_pkg::ACC_LIM_LO : isl_pkg::ACC_LIM_HI;
	assign tsum     = {1'b0, icnt_q} + 13'(tab_width);

	// Type of the token that is open, as it would close now.
	always_comb begin
		cur_type = isl_pkg::TY_UNKNOWN;
		unique case (mode_q)
			isl_pkg::MODE_IDENT: begin
				cur_type = isl_pkg::TY_IDENTIFIER;
				for (int k = 0; k < isl_pkg::KW_NUM; k++) begin
					if (kw_q[k] && CW'(isl_pkg::KW_LEN[k]) == cnt_q)
						cur_type = isl_pkg::KW_CODE[k];
				end
			end
			isl_pkg::MODE_NUM: cur_type = float_q ? isl_pkg::TY_FLOAT : isl_pkg::TY_INT;
			isl_pkg::MODE_OP: begin
				if (la_q == 2'd2)
					cur_type = (pend_q == "<") ? isl_pkg::TY_SHL : isl_pkg::TY_SHR;
				else
					cur_type = isl_pkg::single_code(pend_q);
			end
			default: cur_type = isl_pkg::TY_UNKNOWN;
		endcase
	end

	always_comb begin
		mode_d = mode_q; pend_d = pend_q; la_d = la_q; quote_d = quote_q;
		esc_d = esc_q; float_d = float_q; kw_d = kw_q; cnt_d = cnt_q; acc_d = acc_q;
		icnt_d = icnt_q; top_d = top_q; line_d = line_q; col_d = col_q;
		sline_d = sline_q; scol_d = scol_q;
		escdef_d = escdef_q; ctype_d = ctype_q; nl_d = nl_q;
		push = 1'b0;
		txt_v = 1'b0; txt_b = c;
		dsc_v = 1'b0; dsc_t = cur_type;
		mrk_v = 1'b0; mrk_t = isl_pkg::TY_DEDENT; mrk_col = 16'd1;
		stat.esc_go = 1'b0; stat.body_ind = 1'b0; stat.body_scan = 1'b0;
		stat.body_close = 1'b0; stat.scan_close = 1'b0; stat.ind_stay = 1'b0;
		stat.ded_more = 1'b0;
		stat.eoi      = eoi_q;
		stat.can_gen  = !hold_v_q || out_free;
		stat.flush_ok = !hold_v_q || out_free;

		unique case (cmd.phase)
			isl_pkg::PH_ESC: begin
				if (eoi_q)
					stat.esc_go = (mode_q == isl_pkg::MODE_STR) && esc_q && !full;
				else
					stat.esc_go = (mode_q == isl_pkg::MODE_STR) && esc_q &&
						!(c == "n" || c == "t" || c == "r" || c == "\\" || c == "'" ||
						c == "\"");
				if (stat.esc_go) begin
					txt_v = 1'b1;
					txt_b = "\\";
					if (!eoi_q) begin
						esc_d    = 1'b0;
						escdef_d = 1'b1;
					end
				end
			end
			isl_pkg::PH_BODY: begin
				if (eoi_q) begin
					if (mode_q != isl_pkg::MODE_INDENT && mode_q != isl_pkg::MODE_IDLE)
						dsc_v = 1'b1;
				end else if (escdef_q) begin
					// Unknown escape: the escaped byte follows the backslash if it fits.
					if (!full) begin
						txt_v = 1'b1;
					end else begin
						dsc_v = 1'b1; dsc_t = isl_pkg::TY_UNKNOWN; stat.body_scan = 1'b1;
					end
				end else begin
					unique case (mode_q)
						isl_pkg::MODE_INDENT: begin
							if (c == " ") begin
								if (icnt_q != isl_pkg::INDENT_SAT) icnt_d = icnt_q + 12'd1;
							end else if (c == "\t") begin
								icnt_d = tsum[12] ? isl_pkg::INDENT_SAT : tsum[11:0];
							end else begin
								stat.body_ind = 1'b1;
							end
						end
						isl_pkg::MODE_IDENT: begin
							if ((isl_pkg::is_alpha(c) || isl_pkg::is_digit(c)) && !full) begin
								for (int k = 0; k < isl_pkg::KW_NUM; k++) begin
									if (cnt_q > CW'(6))
										kw_d[k] = 1'b0;
									else if (CW'(isl_pkg::KW_LEN[k]) <= cnt_q ||
										isl_pkg::KW_CH[k][cnt_q[2:0]] != c)
										kw_d[k] = 1'b0;
								end
								txt_v = 1'b1;
							end else begin
								dsc_v = 1'b1; stat.body_scan = 1'b1;
							end
						end
						isl_pkg::MODE_NUM: begin
							if (isl_pkg::is_digit(c) && !full) begin
								acc_d = (acc_q > lim) ? isl_pkg::VALUE_SAT :
									31'({acc_q, 3'b000}) + 31'({acc_q, 1'b0}) + 31'(dv);
								txt_v = 1'b1;
							end else if (c == "." && !float_q && !full) begin
								float_d = 1'b1;
								txt_v   = 1'b1;
							end else begin
								dsc_v = 1'b1; stat.body_scan = 1'b1;
							end
						end
						isl_pkg::MODE_STR: begin
							if (esc_q) begin
								esc_d = 1'b0;
								txt_v = 1'b1;
								if (c == "n") txt_b = 8'h0A;
								else if (c == "t") txt_b = 8'h09;
								else if (c == "r") txt_b = 8'h0D;
							end else if (c == quote_q) begin
								dsc_v = 1'b1; dsc_t = isl_pkg::TY_STRING;
							end else if (full) begin
								dsc_v = 1'b1; dsc_t = isl_pkg::TY_UNKNOWN; stat.body_scan = 1'b1;
							end else if (c == "\\") begin
								esc_d = 1'b1;
							end else begin
								txt_v = 1'b1;
							end
						end
						isl_pkg::MODE_OP: begin
							if (la_q == 2'd2) begin
								if (c == "=") begin
									txt_v = 1'b1;
									ctype_d = (pend_q == "<") ? isl_pkg::TY_SHL_EQ :
										isl_pkg::TY_SHR_EQ;
									stat.body_close = 1'b1;
								end else begin
									dsc_v = 1'b1; stat.body_scan = 1'b1;
								end
							end else if (c == "=") begin
								txt_v = 1'b1; ctype_d = isl_pkg::eq_code(pend_q);
								stat.body_close = 1'b1;
							end else if (pend_q == "*" && c == "*") begin
								txt_v = 1'b1; ctype_d = isl_pkg::TY_POW;
								stat.body_close = 1'b1;
							end else if ((pend_q == "<" || pend_q == ">") && c == pend_q) begin
								txt_v = 1'b1; la_d = 2'd2;
							end else begin
								dsc_v = 1'b1; stat.body_scan = 1'b1;
							end
						end
						default: begin
							mode_d = isl_pkg::MODE_IDLE;
							stat.body_scan = 1'b1;
						end
					endcase
				end
			end
			isl_pkg::PH_IND: begin
				if (icnt_q > cur_lvl) begin
					mrk_v = 1'b1;
					if (top_q == TOP_LAST) begin
						mrk_t = isl_pkg::TY_TOO_DEEP;
					end else begin
						mrk_t = isl_pkg::TY_INDENT;
						push  = 1'b1;
						top_d = top_q + TW'(1);
					end
					mode_d = isl_pkg::MODE_IDLE; icnt_d = 12'd0;
				end else if (top_q != '0 && cur_lvl > icnt_q) begin
					// Pop one level; the run of DEDENTs stops at the first level
					// that is no deeper than the new line.
					mrk_v = 1'b1;
					top_d = top_q - TW'(1);
					if (nxt_lvl > icnt_q) begin
						stat.ind_stay = 1'b1;
					end else begin
						mode_d = isl_pkg::MODE_IDLE; icnt_d = 12'd0;
					end
				end else begin
					mode_d = isl_pkg::MODE_IDLE; icnt_d = 12'd0;
				end
			end
			isl_pkg::PH_SCAN: begin
				if (!(c == " " || c == "\t" || c == 8'h0D)) begin
					sline_d = line_q;
					scol_d  = col_q;
					if (c == "\"" || c == "'") begin
						mode_d = isl_pkg::MODE_STR; quote_d = c; esc_d = 1'b0;
						cnt_d  = '0;
					end else begin
						txt_v = 1'b1;
						if (c == 8'h0A) begin
							ctype_d = isl_pkg::TY_NEWLINE; nl_d = 1'b1;
							stat.scan_close = 1'b1;
						end else if (isl_pkg::is_digit(c)) begin
							mode_d = isl_pkg::MODE_NUM; float_d = 1'b0; acc_d = 31'(dv);
						end else if (isl_pkg::is_alpha(c)) begin
							mode_d = isl_pkg::MODE_IDENT;
							for (int k = 0; k < isl_pkg::KW_NUM; k++)
								kw_d[k] = (isl_pkg::KW_CH[k][0] == c);
						end else if (isl_pkg::is_look_op(c)) begin
							mode_d = isl_pkg::MODE_OP; pend_d = c; la_d = 2'd1;
						end else begin
							ctype_d = isl_pkg::punct_code(c); nl_d = 1'b0;
							stat.scan_close = 1'b1;
						end
					end
				end
			end
			isl_pkg::PH_CLOSE: begin
				dsc_v = 1'b1;
				dsc_t = ctype_q;
			end
			isl_pkg::PH_DED: begin
				if (top_q != '0) begin
					mrk_v = 1'b1;
					top_d = top_q - TW'(1);
					stat.ded_more = 1'b1;
				end
			end
			isl_pkg::PH_END: begin
				mrk_v = 1'b1; mrk_t = isl_pkg::TY_END; mrk_col = col_q;
				mode_d = isl_pkg::MODE_IDLE; icnt_d = 12'd0; top_d = '0;
				line_d = 20'd1; col_d = 16'd1; sline_d = 20'd1; scol_d = 16'd1;
			end
			default: begin
			end
		endcase

		if (txt_v) cnt_d = cnt_q + CW'(1);
		if (dsc_v || (cmd.phase == isl_pkg::PH_END)) begin
			// A closed token clears everything that belongs to it.
			if (dsc_v) mode_d = isl_pkg::MODE_IDLE;
			cnt_d = '0; acc_d = '0; float_d = 1'b0; esc_d = 1'b0; la_d = 2'd0;
			pend_d = 8'd0; quote_d = 8'd0; kw_d = 8'hFF;
		end
		if (cmd.phase == isl_pkg::PH_CLOSE) begin
			nl_d = 1'b0;
			if (nl_q) begin
				mode_d = isl_pkg::MODE_INDENT;
				icnt_d = 12'd0;
			end
		end

		gen   = '0;
		gen_v = txt_v || dsc_v || mrk_v;
		if (txt_v) begin
			gen.text_byte = txt_b;
		end else if (dsc_v) begin
			gen.record_kind  = 1'b1;
			gen.token_type   = dsc_t;
			gen.token_line   = sline_q;
			gen.token_column = scol_q;
			gen.token_length = 9'(cnt_q);
			gen.int_value    = (dsc_t == isl_pkg::TY_INT) ? acc_q : 31'd0;
		end else begin
			gen.record_kind  = 1'b1;
			gen.token_type   = mrk_t;
			gen.token_line   = line_q;
			gen.token_column = mrk_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= isl_pkg::MODE_IDLE; pend_q <= 8'd0; la_q <= 2'd0; quote_q <= 8'd0;
			esc_q <= 1'b0; float_q <= 1'b0; kw_q <= 8'hFF; cnt_q <= '0; acc_q <= '0;
			icnt_q <= 12'd0; top_q <= '0; line_q <= 20'd1; col_q <= 16'd1;
			sline_q <= 20'd1; scol_q <= 16'd1;
			eoi_q <= 1'b0; escdef_q <= 1'b0; ctype_q <= isl_pkg::TY_END; nl_q <= 1'b0;
		end else if (cmd.accept) begin
			eoi_q    <= end_of_input;
			escdef_q <= 1'b0;
		end else if (cmd.step) begin
			mode_q <= mode_d; pend_q <= pend_d; la_q <= la_d; quote_q <= quote_d;
			esc_q <= esc_d; float_q <= float_d; kw_q <= kw_d; cnt_q <= cnt_d; acc_q <= acc_d;
			icnt_q <= icnt_d; top_q <= top_d; line_q <= line_d; col_q <= col_d;
			sline_q <= sline_d; scol_q <= scol_d;
			escdef_q <= escdef_d; ctype_q <= ctype_d; nl_q <= nl_d;
		end else if (cmd.finish && !eoi_q) begin
			// Position advances once the byte is fully handled.
			if (c == 8'h0A) begin
				if (line_q != isl_pkg::LINE_SAT) line_q <= line_q + 20'd1;
				col_q <= 16'd1;
			end else if (col_q != isl_pkg::COL_SAT) begin
				col_q <= col_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) byte_q <= char_byte;
		if (cmd.step && push) lv_q[top_q + TW'(1)] <= icnt_q;
	end

	// Each new record pushes the held one out; the last one leaves at the finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.step && gen_v) begin
				if (hold_v_q) begin
					out_q   <= hold_q;
					out_v_q <= 1'b1;
				end else if (rec_ready) begin
					out_v_q <= 1'b0;
				end
				hold_q   <= gen;
				hold_v_q <= 1'b1;
			end else if (cmd.finish && hold_v_q) begin
				out_q             <= hold_q;
				out_q.last_of_run <= 1'b1;
				out_v_q           <= 1'b1;
				hold_v_q          <= 1'b0;
			end else if (rec_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rec       = out_q;
	assign rec_valid = out_v_q;

endmodule

[design/indent_aware_source_lexer.sv]
// Top level of the indentation-aware source lexer: channels, register port, wiring.
// Depends on isl_pkg, the interfaces in isl_if, isl_ctrl and isl_dp.
//
//   Channel   Direction  Payload
//   char_in   in         char_byte, end_of_input
//   rec_out   out        record_kind, text_byte, token_type, token_line,
//                        token_column, token_length, int_value, last_of_run
//   APB       in/out     tab_width, read at address 0, written at any address
//
// The block takes one source byte per transfer and works on it alone. A byte
// passes through an accept step, an escape check, a body step and a finish
// step, plus a further step for each thing it needs: indent resolution, each
// DEDENT popped from the stack, rescanning the byte and a closing descriptor.
// Reset clears all scanner state; the indentation stack needs no clearing pass,
// since its bottom level is fixed at zero and deeper entries are written on push.
// A stalled record output holds the sequencer once its one-record hold stage
// is full; input is taken only while the block is between bytes.
module indent_aware_source_lexer #(
	parameter int TOKEN_MAX_BYTES = 256,
	parameter int INDENT_DEPTH    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	isl_char_if.sink    char_in,
	isl_rec_if.source   rec_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	isl_pkg::isl_cmd_t  cmd;
	isl_pkg::isl_stat_t stat;
	isl_pkg::isl_rec_t  rec;
	logic               rec_valid;
	logic [3:0]         tab_q;

	// Configuration register. Writes must arrive only while the lexer is idle; the block does not enforce it.
	assign pready = 1'b1;
	assign prdata = (paddr == isl_pkg::REG_TAB_WIDTH) ? {28'd0, tab_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= isl_pkg::TAB_RESET;
		end else if (psel && penable && pwrite) begin
			tab_q <= pwdata[3:0];
		end
	end

	isl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_in.valid),
		.in_ready (char_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	isl_dp #(
		.TOKEN_MAX_BYTES (TOKEN_MAX_BYTES),
		.INDENT_DEPTH    (INDENT_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.char_byte    (char_in.char_byte),
		.end_of_input (char_in.end_of_input),
		.tab_width    (tab_q),
		.rec          (rec),
		.rec_valid    (rec_valid),
		.rec_ready    (rec_out.ready)
	);

	// Each output transfer carries one record from the output register.
	assign rec_out.valid        = rec_valid;
	assign rec_out.record_kind  = rec.record_kind;
	assign rec_out.text_byte    = rec.text_byte;
	assign rec_out.token_type   = rec.token_type;
	assign rec_out.token_line   = rec.token_line;
	assign rec_out.token_column = rec.token_column;
	assign rec_out.token_length = rec.token_length;
	assign rec_out.int_value    = rec.int_value;
	assign rec_out.last_of_run  = rec.last_of_run;

endmodule

[verif/tb.sv]
// Self-checking testbench of indent_aware_source_lexer: a byte stream in, records out.
// Depends on isl_pkg and on the isl_char_if and isl_rec_if interfaces of the design.
// A local lexer model predicts every record; a monitor checks them in order.
module tb;
	import isl_pkg::*;

	localparam int MAX_BYTES  = 256;
	localparam int STACK_SIZE = 16;
	localparam int MAX_RECS   = 20;
	localparam int WATCHDOG   = 20000;
	localparam int SETTLE     = 40;

	// Keyword codes; they have no names in the package.
	localparam logic [5:0] TY_KW_IF     = 6'd38;
	localparam logic [5:0] TY_KW_ELSE   = 6'd39;
	localparam logic [5:0] TY_KW_WHILE  = 6'd40;
	localparam logic [5:0] TY_KW_FOR    = 6'd41;
	localparam logic [5:0] TY_KW_DEF    = 6'd42;
	localparam logic [5:0] TY_KW_RETURN = 6'd43;
	localparam logic [5:0] TY_KW_ELIF   = 6'd44;
	localparam logic [5:0] TY_KW_PRINT  = 6'd48;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} src_item_t;

	string      kw_word [8] = '{"if", "elif", "else", "while", "for", "def", "return", "print"};
	logic [5:0] kw_type [8] = '{TY_KW_IF, TY_KW_ELIF, TY_KW_ELSE, TY_KW_WHILE, TY_KW_FOR,
		TY_KW_DEF, TY_KW_RETURN, TY_KW_PRINT};
	string      op_word [28] = '{"+", "-", "*", "/", "**", "<<", ">>", "<<=", ">>=", "&", "|",
		"^", "~", "==", "!=", "<", "<=", ">", ">=", "=", "+=", "-=", "*=", "/=", "&=", "|=",
		"^=", "!"};
	string      punct_chars = "()[],:";

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	isl_char_if char_in ();
	isl_rec_if  rec_out ();

	indent_aware_source_lexer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_in),
		.rec_out (rec_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Source bytes waiting for the driver, and records the lexer model still owes.
	src_item_t   src_q[$];
	isl_rec_t    owed_recs[$];
	int          fail_cnt = 0;
	int          rec_cnt = 0;
	logic        src_taken = 1'b0;

	// Lexer model state.
	logic [3:0]  tab_cols = TAB_RESET;
	logic [2:0]  lx_mode;
	logic [7:0]  lx_op;
	int          lx_look;
	logic [7:0]  lx_quote;
	logic        lx_esc;
	logic        lx_dot;
	logic [7:0]  lx_kw;
	int          lx_len;
	int unsigned lx_val;
	int          lx_ind;
	int          lx_lvl [STACK_SIZE];
	int          lx_top;
	int unsigned lx_line, lx_col, tok_line, tok_col;
	isl_rec_t    step_recs[$];

	function automatic void clear_lexer();
		lx_mode = MODE_IDLE;
		lx_op = 8'd0;
		lx_look = 0;
		lx_quote = 8'd0;
		lx_esc = 1'b0;
		lx_dot = 1'b0;
		lx_kw = 8'hFF;
		lx_len = 0;
		lx_val = 0;
		lx_ind = 0;
		foreach (lx_lvl[i]) lx_lvl[i] = 0;
		lx_top = 0;
		lx_line = 1;
		lx_col = 1;
		tok_line = 1;
		tok_col = 1;
	endfunction

	function automatic void emit(logic kind, logic [7:0] tb_, logic [5:0] ty, int unsigned ln,
		int unsigned col, int len, int unsigned val);
		isl_rec_t r;
		if (step_recs.size() >= MAX_RECS) return;
		r.record_kind = kind;
		r.text_byte = tb_;
		r.token_type = ty;
		r.token_line = ln[19:0];
		r.token_column = col[15:0];
		r.token_length = len[8:0];
		r.int_value = val[30:0];
		r.last_of_run = 1'b0;
		step_recs.push_back(r);
	endfunction

	function automatic void emit_text(logic [7:0] b);
		emit(1'b0, b, TY_END, 0, 0, 0, 0);
		lx_len++;
	endfunction

	function automatic void emit_marker(logic [5:0] ty, int unsigned ln);
		emit(1'b1, 8'd0, ty, ln, 1, 0, 0);
	endfunction

	function automatic void close_token(logic [5:0] ty);
		emit(1'b1, 8'd0, ty, tok_line, tok_col, lx_len, ty == TY_INT ? lx_val : 0);
		lx_mode = MODE_IDLE;
		lx_len = 0;
		lx_val = 0;
		lx_dot = 1'b0;
		lx_esc = 1'b0;
		lx_look = 0;
		lx_op = 8'd0;
		lx_quote = 8'd0;
		lx_kw = 8'hFF;
	endfunction

	function automatic logic letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Operator characters that may combine with the byte after them.
	function automatic logic op_head(logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "<", ">", "=", "!", "&", "|", "^": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [5:0] op_alone(logic [7:0] op);
		case (op)
			"+": return TY_PLUS;
			"-": return TY_MINUS;
			"*": return TY_STAR;
			"/": return TY_SLASH;
			"<": return TY_LT;
			">": return TY_GT;
			"=": return TY_ASSIGN;
			"&": return TY_AMP;
			"|": return TY_BAR;
			"^": return TY_CARET;
			default: return TY_UNKNOWN;
		endcase
	endfunction

	function automatic logic [5:0] op_with_eq(logic [7:0] op);
		case (op)
			"+": return TY_PLUS_EQ;
			"-": return TY_MINUS_EQ;
			"*": return TY_STAR_EQ;
			"/": return TY_SLASH_EQ;
			"<": return TY_LE;
			">": return TY_GE;
			"=": return TY_EQ;
			"!": return TY_NE;
			"&": return TY_AMP_EQ;
			"|": return TY_BAR_EQ;
			default: return TY_CARET_EQ;
		endcase
	endfunction

	function automatic logic [5:0] punct_type(logic [7:0] c);
		case (c)
			"~": return TY_TILDE;
			"(": return TY_LPAREN;
			")": return TY_RPAREN;
			"[": return TY_LBRACK;
			"]": return TY_RBRACK;
			",": return TY_COMMA;
			":": return TY_COLON;
			default: return TY_UNKNOWN;
		endcase
	endfunction

	function automatic void narrow_keywords(logic [7:0] c, int pos);
		for (int k = 0; k < 8; k++)
			if (pos >= kw_word[k].len() || kw_word[k][pos] != c) lx_kw[k] = 1'b0;
	endfunction

	function automatic void close_open_token();
		logic [5:0] ty;
		ty = TY_IDENTIFIER;
		case (lx_mode)
			MODE_IDENT: begin
				for (int k = 0; k < 8; k++)
					if (lx_kw[k] && kw_word[k].len() == lx_len) ty = kw_type[k];
				close_token(ty);
			end
			MODE_NUM: close_token(lx_dot ? TY_FLOAT : TY_INT);
			MODE_STR: close_token(TY_UNKNOWN);
			MODE_OP: begin
				if (lx_look == 2) close_token(lx_op == "<" ? TY_SHL : TY_SHR);
				else close_token(op_alone(lx_op));
			end
			default: lx_mode = MODE_IDLE;
		endcase
	endfunction

	function automatic void open_token(logic [2:0] m, int unsigned ln, int unsigned col);
		lx_mode = m;
		tok_line = ln;
		tok_col = col;
		lx_len = 0;
	endfunction

	// Byte seen between tokens: skip blanks or start a new token.
	function automatic void scan_fresh(logic [7:0] c, int unsigned ln, int unsigned col);
		if (c == " " || c == "\t" || c == "\r") return;
		if (c == "\n") begin
			open_token(MODE_IDLE, ln, col);
			emit_text(c);
			close_token(TY_NEWLINE);
			lx_mode = MODE_INDENT;
			lx_ind = 0;
		end else if (numeral(c)) begin
			open_token(MODE_NUM, ln, col);
			lx_dot = 1'b0;
			lx_val = c - "0";
			emit_text(c);
		end else if (c == "\"" || c == "'") begin
			open_token(MODE_STR, ln, col);
			lx_quote = c;
			lx_esc = 1'b0;
		end else if (letter(c)) begin
			open_token(MODE_IDENT, ln, col);
			lx_kw = 8'hFF;
			narrow_keywords(c, 0);
			emit_text(c);
		end else if (op_head(c)) begin
			open_token(MODE_OP, ln, col);
			lx_op = c;
			lx_look = 1;
			emit_text(c);
		end else begin
			open_token(MODE_IDLE, ln, col);
			emit_text(c);
			close_token(punct_type(c));
		end
	endfunction

	// Compare the measured line start against the stack of open levels.
	function automatic void settle_indent(int unsigned ln);
		if (lx_ind > lx_lvl[lx_top]) begin
			if (lx_top + 1 >= STACK_SIZE) begin
				emit_marker(TY_TOO_DEEP, ln);
			end else begin
				lx_top++;
				lx_lvl[lx_top] = lx_ind;
				emit_marker(TY_INDENT, ln);
			end
		end else if (lx_ind < lx_lvl[lx_top]) begin
			while (lx_top > 0 && lx_lvl[lx_top] > lx_ind) begin
				lx_top--;
				emit_marker(TY_DEDENT, ln);
			end
		end
		lx_mode = MODE_IDLE;
		lx_ind = 0;
	endfunction

	function automatic void scan_quoted(logic [7:0] c, int unsigned ln, int unsigned col);
		logic [7:0] d;
		if (lx_esc) begin
			lx_esc = 1'b0;
			case (c)
				"n": d = "\n";
				"t": d = "\t";
				"r": d = "\r";
				"\\", "'", "\"": d = c;
				default: begin
					// Unknown escapes keep the backslash and the byte.
					emit_text("\\");
					if (lx_len < MAX_BYTES) begin
						emit_text(c);
					end else begin
						close_token(TY_UNKNOWN);
						scan_fresh(c, ln, col);
					end
					return;
				end
			endcase
			emit_text(d);
			return;
		end
		if (c == lx_quote) close_token(TY_STRING);
		else if (lx_len >= MAX_BYTES) begin
			close_token(TY_UNKNOWN);
			scan_fresh(c, ln, col);
		end else if (c == "\\") lx_esc = 1'b1;
		else emit_text(c);
	endfunction

	function automatic void scan_operator(logic [7:0] c, int unsigned ln, int unsigned col);
		if (lx_look == 2) begin
			if (c == "=") begin
				emit_text(c);
				close_token(lx_op == "<" ? TY_SHL_EQ : TY_SHR_EQ);
			end else begin
				close_open_token();
				scan_fresh(c, ln, col);
			end
		end else if (c == "=") begin
			emit_text(c);
			close_token(op_with_eq(lx_op));
		end else if (lx_op == "*" && c == "*") begin
			emit_text(c);
			close_token(TY_POW);
		end else if ((lx_op == "<" || lx_op == ">") && c == lx_op) begin
			emit_text(c);
			lx_look = 2;
		end else begin
			close_open_token();
			scan_fresh(c, ln, col);
		end
	endfunction

	// Work out every record one source transfer causes and queue them.
	function automatic void lex_transfer(logic [7:0] c, logic eoi);
		int unsigned ln, col, dig;
		ln = lx_line;
		col = lx_col;
		step_recs.delete();
		if (eoi) begin
			if (lx_mode == MODE_STR && lx_esc && lx_len < MAX_BYTES) emit_text("\\");
			if (lx_mode != MODE_INDENT && lx_mode != MODE_IDLE) close_open_token();
			while (lx_top > 0) begin
				lx_top--;
				emit_marker(TY_DEDENT, ln);
			end
			emit(1'b1, 8'd0, TY_END, ln, col, 0, 0);
			clear_lexer();
		end else begin
			case (lx_mode)
				MODE_INDENT: begin
					if (c == " ") begin
						if (lx_ind < INDENT_SAT) lx_ind++;
					end else if (c == "\t") begin
						lx_ind += tab_cols;
						if (lx_ind > INDENT_SAT) lx_ind = INDENT_SAT;
					end else begin
						settle_indent(ln);
						scan_fresh(c, ln, col);
					end
				end
				MODE_IDENT: begin
					if ((letter(c) || numeral(c)) && lx_len < MAX_BYTES) begin
						narrow_keywords(c, lx_len);
						emit_text(c);
					end else begin
						close_open_token();
						scan_fresh(c, ln, col);
					end
				end
				MODE_NUM: begin
					if (numeral(c) && lx_len < MAX_BYTES) begin
						dig = c - "0";
						if (lx_val > (VALUE_SAT - dig) / 10) lx_val = VALUE_SAT;
						else lx_val = lx_val * 10 + dig;
						emit_text(c);
					end else if (c == "." && !lx_dot && lx_len < MAX_BYTES) begin
						lx_dot = 1'b1;
						emit_text(c);
					end else begin
						close_open_token();
						scan_fresh(c, ln, col);
					end
				end
				MODE_STR: scan_quoted(c, ln, col);
				MODE_OP: scan_operator(c, ln, col);
				default: begin
					lx_mode = MODE_IDLE;
					scan_fresh(c, ln, col);
				end
			endcase
			if (c == "\n") begin
				if (lx_line < LINE_SAT) lx_line++;
				lx_col = 1;
			end else if (lx_col < COL_SAT) begin
				lx_col++;
			end
		end
		if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_run = 1'b1;
		foreach (step_recs[i]) owed_recs.push_back(step_recs[i]);
	endfunction

	// Monitor: predicts on every source transfer, checks every record transfer,
	// and ends the run when nothing moves for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		isl_rec_t want;
		src_taken <= char_in.valid && char_in.ready;
		if (char_in.valid && char_in.ready) lex_transfer(char_in.char_byte, char_in.end_of_input);
		if (rec_out.valid && rec_out.ready) begin
			rec_cnt++;
			if (owed_recs.size() == 0) begin
				$error("record with nothing expected: kind %0d type %0d", rec_out.record_kind,
					rec_out.token_type);
				fail_cnt++;
			end else begin
				want = owed_recs.pop_front();
				if (rec_out.record_kind !== want.record_kind) begin
					$error("record_kind: expected %0d, got %0d", want.record_kind,
						rec_out.record_kind);
					fail_cnt++;
				end
				if (rec_out.text_byte !== want.text_byte) begin
					$error("text_byte: expected %0d, got %0d", want.text_byte, rec_out.text_byte);
					fail_cnt++;
				end
				if (rec_out.token_type !== want.token_type) begin
					$error("token_type: expected %0d, got %0d", want.token_type,
						rec_out.token_type);
					fail_cnt++;
				end
				if (rec_out.token_line !== want.token_line) begin
					$error("token_line: expected %0d, got %0d", want.token_line,
						rec_out.token_line);
					fail_cnt++;
				end
				if (rec_out.token_column !== want.token_column) begin
					$error("token_column: expected %0d, got %0d", want.token_column,
						rec_out.token_column);
					fail_cnt++;
				end
				if (rec_out.token_length !== want.token_length) begin
					$error("token_length: expected %0d, got %0d", want.token_length,
						rec_out.token_length);
					fail_cnt++;
				end
				if (rec_out.int_value !== want.int_value) begin
					$error("int_value: expected %0d, got %0d", want.int_value,
						rec_out.int_value);
					fail_cnt++;
				end
				if (rec_out.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d", want.last_of_run,
						rec_out.last_of_run);
					fail_cnt++;
				end
			end
		end
		if ((char_in.valid && char_in.ready) || (rec_out.valid && rec_out.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// Driver: offers queued bytes in bursts of random length, with random gaps
	// in between. A new item replaces the old one only after its transfer.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		src_item_t it;
		if (arst_n && (!char_in.valid || src_taken)) begin
			if (gap_left > 0 || src_q.size() == 0) begin
				if (gap_left > 0) gap_left--;
				char_in.valid <= 1'b0;
			end else begin
				it = src_q.pop_front();
				char_in.valid <= 1'b1;
				char_in.char_byte <= it.ch;
				char_in.end_of_input <= it.eoi;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
		end
	end

	// Receiver: alternates stretches of full throughput with random stalls, and
	// once holds off long enough that the block backs up to its input.
	int hold_left = 0;
	logic held_once = 1'b0;
	int stretch = 0;
	always @(negedge clk) begin
		logic rdy;
		stretch++;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!held_once && rec_cnt >= 80) begin
			held_once = 1'b1;
			hold_left = 400;
			rdy = 1'b0;
		end else if ((stretch / 64) % 3 == 0) begin
			rdy = 1'b1;
		end else begin
			rdy = ($urandom_range(0, 3) != 0);
		end
		rec_out.ready <= rdy;
	end

	task automatic queue_byte(logic [7:0] c);
		src_item_t it;
		it.ch = c;
		it.eoi = 1'b0;
		src_q.push_back(it);
	endtask

	task automatic queue_end();
		src_item_t it;
		it.ch = $urandom_range(0, 255);
		it.eoi = 1'b1;
		src_q.push_back(it);
	endtask

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
	endtask

	task automatic write_tab_width(logic [3:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_TAB_WIDTH;
		pwdata <= {28'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tab_cols = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every queued byte has gone in and every record has come out,
	// then lets the block finish any byte that produces nothing.
	task automatic drain();
		@(posedge clk);
		while (src_q.size() != 0 || char_in.valid || owed_recs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One random token drawn from the language, plus the odd stray byte.
	task automatic queue_token();
		int n;
		case ($urandom_range(0, 9))
			0, 1: queue_text(kw_word[$urandom_range(0, 7)]);
			2, 3: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 3))
						0: queue_byte($urandom_range("A", "Z"));
						1: queue_byte($urandom_range("0", "9"));
						2: queue_byte("_");
						default: queue_byte($urandom_range("a", "z"));
					endcase
				end
			end
			4: begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) queue_byte($urandom_range("0", "9"));
				if ($urandom_range(0, 2) == 0) begin
					queue_byte(".");
					queue_byte($urandom_range("0", "9"));
					if ($urandom_range(0, 2) == 0) queue_byte(".");
				end
			end
			5: begin
				queue_byte($urandom_range(0, 1) ? "'" : "\"");
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 3) == 0) begin
						queue_byte("\\");
						case ($urandom_range(0, 7))
							0: queue_byte("n");
							1: queue_byte("t");
							2: queue_byte("r");
							3: queue_byte("\\");
							4: queue_byte("'");
							5: queue_byte("\"");
							default: queue_byte($urandom_range(" ", "~"));
						endcase
					end else begin
						queue_byte($urandom_range(" ", "~"));
					end
				end
				if ($urandom_range(0, 7) != 0) queue_byte($urandom_range(0, 1) ? "'" : "\"");
			end
			6, 7: queue_text(op_word[$urandom_range(0, 27)]);
			8: queue_byte(punct_chars[$urandom_range(0, 5)]);
			default: queue_byte($urandom_range(0, 255));
		endcase
	endtask

	task automatic queue_line();
		int n;
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) queue_byte($urandom_range(0, 2) ? " " : "\t");
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			queue_token();
			case ($urandom_range(0, 5))
				0: ;
				1: queue_byte("\t");
				2: queue_byte("\r");
				default: queue_byte(" ");
			endcase
		end
		queue_byte("\n");
		if ($urandom_range(0, 15) == 0) queue_end();
	endtask

	task automatic queue_random_lines(int nbytes);
		int start;
		start = src_q.size();
		while (src_q.size() - start < nbytes) queue_line();
		queue_end();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = REG_TAB_WIDTH;
		pwdata = 32'd0;
		char_in.valid = 1'b0;
		char_in.char_byte = 8'd0;
		char_in.end_of_input = 1'b0;
		rec_out.ready = 1'b0;
		clear_lexer();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: keywords, operators with lookahead, saturated integer,
		// second dot, escapes, punctuation, byte extremes, indents and a
		// dedent to a width that matches no level, then an open string at end.
		queue_text("  if elif else while for def return print x_9\n");
		queue_text("\t** <<= >>= << >> != ! == 99999999999 1.2.3\n");
		queue_text("    'a\\n\\q' \"b\\\"\" ~()[],:@\r");
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_text("\n        z\n      w\n  v\n");
		queue_text("'ab\\");
		queue_end();
		drain();

		// Narrowest tab.
		write_tab_width(4'd1);
		queue_text("\t\tx\n\ty\n");
		queue_end();
		drain();

		// Out-of-range widths are used as written.
		write_tab_width(4'd0);
		queue_random_lines(6);
		drain();
		write_tab_width(4'd15);
		queue_random_lines(6);
		drain();

		if (fail_cnt == 0 && owed_recs.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
